// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent on the same edge
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cpu8_pkg.sv
// ---------------------------------------------------------------------------
// cpu8_pkg
// types, opcode codes and constants of the 8-bit cpu execute stage
// ---------------------------------------------------------------------------
package cpu8_pkg;

	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 24;

	// status bit positions, NV-BDIZC
	localparam logic [2:0] F_C = 3'd0;
	localparam logic [2:0] F_Z = 3'd1;
	localparam logic [2:0] F_I = 3'd2;
	localparam logic [2:0] F_D = 3'd3;
	localparam logic [2:0] F_V = 3'd6;
	localparam logic [2:0] F_N = 3'd7;

	localparam logic [7:0] SP_RESET = 8'hFF;

	// decimal correction
	localparam logic [4:0] BCD_LO_LIMIT = 5'd10;
	localparam logic [7:0] BCD_ADJ_LO   = 8'h06;
	localparam logic [7:0] BCD_ADJ_HI   = 8'h60;
	localparam logic [9:0] BCD_HI_LIMIT = 10'h0A0;
	localparam logic [9:0] BCD_DIGIT_CY = 10'h010;

	// opcode fields: row op[7:5], mode op[4:2], group op[1:0]
	localparam logic [1:0] GRP_CTL     = 2'b00;
	localparam logic [1:0] GRP_ALU     = 2'b01;
	localparam logic [1:0] GRP_RMW     = 2'b10;
	localparam logic [2:0] MODE_ACC    = 3'b010;
	localparam logic [2:0] MODE_ZPIND  = 3'b100;
	localparam logic [2:0] MODE_BRANCH = 3'b100;
	localparam logic [2:0] ROW_DEC     = 3'b110;
	localparam logic [2:0] ROW_INC     = 3'b111;

	// opcodes outside the regular groups
	localparam logic [7:0] OP_BIT_IMM = 8'h89, OP_BIT_ZP = 8'h24, OP_BIT_ABS = 8'h2C,
		OP_BIT_ZPX = 8'h34, OP_BIT_ABSX = 8'h3C;
	localparam logic [7:0] OP_TSB_ZP = 8'h04, OP_TSB_ABS = 8'h0C, OP_TRB_ZP = 8'h14,
		OP_TRB_ABS = 8'h1C;
	localparam logic [7:0] OP_STZ_ZP = 8'h64, OP_STZ_ZPX = 8'h74, OP_STZ_ABS = 8'h9C,
		OP_STZ_ABSX = 8'h9E;
	localparam logic [7:0] OP_STY_ZP = 8'h84, OP_STY_ABS = 8'h8C, OP_STY_ZPX = 8'h94;
	localparam logic [7:0] OP_STX_ZP = 8'h86, OP_STX_ABS = 8'h8E, OP_STX_ZPY = 8'h96;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0, OP_LDY_ZP = 8'hA4, OP_LDY_ABS = 8'hAC,
		OP_LDY_ZPX = 8'hB4, OP_LDY_ABSX = 8'hBC;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2, OP_LDX_ZP = 8'hA6, OP_LDX_ABS = 8'hAE,
		OP_LDX_ZPY = 8'hB6, OP_LDX_ABSY = 8'hBE;
	localparam logic [7:0] OP_CPY_IMM = 8'hC0, OP_CPY_ZP = 8'hC4, OP_CPY_ABS = 8'hCC;
	localparam logic [7:0] OP_CPX_IMM = 8'hE0, OP_CPX_ZP = 8'hE4, OP_CPX_ABS = 8'hEC;
	localparam logic [7:0] OP_INA = 8'h1A, OP_DEA = 8'h3A, OP_INX = 8'hE8, OP_DEX = 8'hCA,
		OP_INY = 8'hC8, OP_DEY = 8'h88;
	localparam logic [7:0] OP_TAX = 8'hAA, OP_TAY = 8'hA8, OP_TXA = 8'h8A, OP_TYA = 8'h98,
		OP_TSX = 8'hBA, OP_TXS = 8'h9A;
	localparam logic [7:0] OP_PHA = 8'h48, OP_PHP = 8'h08, OP_PHX = 8'hDA, OP_PHY = 8'h5A;
	localparam logic [7:0] OP_PLA = 8'h68, OP_PLP = 8'h28, OP_PLX = 8'hFA, OP_PLY = 8'h7A;
	localparam logic [7:0] OP_BRA = 8'h80, OP_NOP = 8'hEA;
	localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_CLI = 8'h58, OP_SEI = 8'h78,
		OP_CLV = 8'hB8, OP_CLD = 8'hD8, OP_SED = 8'hF8;

	typedef enum logic [5:0] {
		K_UNK, K_NOP, K_ALU, K_SHM, K_SHA, K_INCM, K_DECM,
		K_INA, K_DEA, K_INX, K_DEX, K_INY, K_DEY,
		K_LDX, K_LDY, K_STX, K_STY, K_STZ, K_CPX, K_CPY,
		K_BIT, K_BITI, K_TSB, K_TRB,
		K_TAX, K_TAY, K_TXA, K_TYA, K_TSX, K_TXS,
		K_PHA, K_PHP, K_PHX, K_PHY, K_PLA, K_PLP, K_PLX, K_PLY,
		K_BR, K_BRA, K_CLC, K_SEC, K_CLI, K_SEI, K_CLV, K_CLD, K_SED
	} kind_t;

	// row meaning in the alu group
	typedef enum logic [2:0] {
		ALU_ORA, ALU_AND, ALU_EOR, ALU_ADC, ALU_STA, ALU_LDA, ALU_CMP, ALU_SBC
	} alu_op_t;

	// row[1:0] in the shift group
	typedef enum logic [1:0] {SH_ASL, SH_ROL, SH_LSR, SH_ROR} shift_t;

	// row[2:1] in the branch group
	typedef enum logic [1:0] {BF_N, BF_V, BF_C, BF_Z} br_flag_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] row;
	} dec_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} regs_t;

	typedef struct packed {
		logic       unknown_opcode;
		logic [7:0] status_out;
		logic       branch_taken;
		logic       write_enable;
		logic [7:0] write_data;
	} res_t;

endpackage

// File: hw/rtl/cpu8_dec.sv
// ---------------------------------------------------------------------------
// cpu8_dec
// opcode decoder: sorts an opcode byte into an operation kind and row
// ---------------------------------------------------------------------------
module cpu8_dec (
	input  logic [7:0]     opcode,
	output cpu8_pkg::dec_t dec
);
	import cpu8_pkg::*;

	logic [2:0] row;
	logic [2:0] mode;
	logic [1:0] grp;

	assign row  = opcode[7:5];
	assign mode = opcode[4:2];
	assign grp  = opcode[1:0];

	always_comb begin
		dec.row = row;
		unique case (opcode)
			OP_BIT_IMM: dec.kind = K_BITI;
			OP_BIT_ZP, OP_BIT_ABS, OP_BIT_ZPX, OP_BIT_ABSX: dec.kind = K_BIT;
			OP_TSB_ZP, OP_TSB_ABS: dec.kind = K_TSB;
			OP_TRB_ZP, OP_TRB_ABS: dec.kind = K_TRB;
			OP_STZ_ZP, OP_STZ_ZPX, OP_STZ_ABS, OP_STZ_ABSX: dec.kind = K_STZ;
			OP_STY_ZP, OP_STY_ABS, OP_STY_ZPX: dec.kind = K_STY;
			OP_STX_ZP, OP_STX_ABS, OP_STX_ZPY: dec.kind = K_STX;
			OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDY_ABSX: dec.kind = K_LDY;
			OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ABS, OP_LDX_ZPY, OP_LDX_ABSY: dec.kind = K_LDX;
			OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS: dec.kind = K_CPY;
			OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS: dec.kind = K_CPX;
			OP_INA: dec.kind = K_INA;
			OP_DEA: dec.kind = K_DEA;
			OP_INX: dec.kind = K_INX;
			OP_DEX: dec.kind = K_DEX;
			OP_INY: dec.kind = K_INY;
			OP_DEY: dec.kind = K_DEY;
			OP_TAX: dec.kind = K_TAX;
			OP_TAY: dec.kind = K_TAY;
			OP_TXA: dec.kind = K_TXA;
			OP_TYA: dec.kind = K_TYA;
			OP_TSX: dec.kind = K_TSX;
			OP_TXS: dec.kind = K_TXS;
			OP_PHA: dec.kind = K_PHA;
			OP_PHP: dec.kind = K_PHP;
			OP_PHX: dec.kind = K_PHX;
			OP_PHY: dec.kind = K_PHY;
			OP_PLA: dec.kind = K_PLA;
			OP_PLP: dec.kind = K_PLP;
			OP_PLX: dec.kind = K_PLX;
			OP_PLY: dec.kind = K_PLY;
			OP_BRA: dec.kind = K_BRA;
			OP_NOP: dec.kind = K_NOP;
			OP_CLC: dec.kind = K_CLC;
			OP_SEC: dec.kind = K_SEC;
			OP_CLI: dec.kind = K_CLI;
			OP_SEI: dec.kind = K_SEI;
			OP_CLV: dec.kind = K_CLV;
			OP_CLD: dec.kind = K_CLD;
			OP_SED: dec.kind = K_SED;
			default: begin
				priority if (grp == GRP_ALU || (grp == GRP_RMW && mode == MODE_ZPIND))
					dec.kind = K_ALU;
				else if (grp == GRP_RMW && !row[2] && mode[0])
					dec.kind = K_SHM;
				else if (grp == GRP_RMW && !row[2] && mode == MODE_ACC)
					dec.kind = K_SHA;
				else if (grp == GRP_RMW && row == ROW_INC && mode[0])
					dec.kind = K_INCM;
				else if (grp == GRP_RMW && row == ROW_DEC && mode[0])
					dec.kind = K_DECM;
				else if (grp == GRP_CTL && mode == MODE_BRANCH)
					dec.kind = K_BR;
				else
					dec.kind = K_UNK;
			end
		endcase
	end

endmodule

// File: hw/rtl/cpu8_alu.sv
// ---------------------------------------------------------------------------
// cpu8_alu
// execute logic: next register state and result for one decoded request
// ---------------------------------------------------------------------------
module cpu8_alu (
	input  cpu8_pkg::dec_t  dec,
	input  logic [7:0]      operand,
	input  cpu8_pkg::regs_t cur,
	output cpu8_pkg::regs_t nxt,
	output cpu8_pkg::res_t  res
);
	import cpu8_pkg::*;

	function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
		logic [7:0] q;
		q = p;
		q[F_N] = v[7];
		q[F_Z] = (v == 8'd0);
		return q;
	endfunction

	// returns {carry out, shifted value}
	function automatic logic [8:0] shift_op(shift_t kind, logic [7:0] v, logic cin);
		logic [8:0] r;
		unique case (kind)
			SH_ASL: r = {v[7], v[6:0], 1'b0};
			SH_ROL: r = {v[7], v[6:0], cin};
			SH_LSR: r = {v[0], 1'b0, v[7:1]};
			SH_ROR: r = {v[0], cin, v[7:1]};
			default: r = {v[0], 1'b0, v[7:1]};
		endcase
		return r;
	endfunction

	logic [4:0] adc_lo;
	logic [9:0] adc_bin;
	logic [9:0] adc_fix_lo;
	logic [9:0] adc_dec1;
	logic [9:0] adc_dec2;
	logic [9:0] adc_t;
	logic [7:0] adc_res;
	logic       adc_v;
	logic [9:0] sbc_full;
	logic [4:0] sbc_lo;
	logic [7:0] sbc_res;
	logic       sbc_v;
	logic [8:0] sh_mem;
	logic [8:0] sh_acc;
	logic [7:0] and_am;
	logic       flag_sel;
	logic [7:0] cmp_reg;
	logic [7:0] cmp_diff;

	// binary and decimal add
	always_comb begin
		adc_lo     = 5'(cur.a[3:0]) + 5'(operand[3:0]) + 5'(cur.p[F_C]);
		adc_bin    = 10'(cur.a) + 10'(operand) + 10'(cur.p[F_C]);
		adc_fix_lo = (adc_lo >= BCD_LO_LIMIT)
			? 10'(4'(adc_lo + BCD_ADJ_LO[4:0])) + BCD_DIGIT_CY
			: 10'(adc_lo);
		adc_dec1   = adc_fix_lo + 10'({cur.a[7:4], 4'd0}) + 10'({operand[7:4], 4'd0});
		adc_dec2   = (adc_dec1 >= BCD_HI_LIMIT) ? adc_dec1 + 10'(BCD_ADJ_HI) : adc_dec1;
		adc_t      = cur.p[F_D] ? adc_dec2 : adc_bin;
		adc_res    = adc_t[7:0];
		adc_v      = ~(cur.a[7] ^ operand[7]) & (adc_res[7] ^ operand[7]);
	end

	// binary and decimal subtract
	always_comb begin
		sbc_full = 10'(cur.a) - 10'(operand) - 10'(!cur.p[F_C]);
		sbc_lo   = 5'(cur.a[3:0]) - 5'(operand[3:0]) - 5'(!cur.p[F_C]);
		sbc_res  = sbc_full[7:0]
			- ((cur.p[F_D] && sbc_full[9]) ? BCD_ADJ_HI : 8'd0)
			- ((cur.p[F_D] && sbc_lo[4]) ? BCD_ADJ_LO : 8'd0);
		sbc_v    = (cur.a[7] ^ operand[7]) & ~(sbc_res[7] ^ operand[7]);
	end

	always_comb begin
		sh_mem = shift_op(shift_t'(dec.row[1:0]), operand, cur.p[F_C]);
		sh_acc = shift_op(shift_t'(dec.row[1:0]), cur.a, cur.p[F_C]);
		and_am = cur.a & operand;
		unique case (br_flag_t'(dec.row[2:1]))
			BF_N: flag_sel = cur.p[F_N];
			BF_V: flag_sel = cur.p[F_V];
			BF_C: flag_sel = cur.p[F_C];
			BF_Z: flag_sel = cur.p[F_Z];
			default: flag_sel = cur.p[F_Z];
		endcase
		priority case (dec.kind)
			K_CPX: cmp_reg = cur.x;
			K_CPY: cmp_reg = cur.y;
			default: cmp_reg = cur.a;
		endcase
		cmp_diff = cmp_reg - operand;
	end

	always_comb begin
		nxt                = cur;
		res.write_data     = 8'd0;
		res.write_enable   = 1'b0;
		res.branch_taken   = 1'b0;
		res.unknown_opcode = 1'b0;
		unique case (dec.kind)
			K_ALU: begin
				unique case (alu_op_t'(dec.row))
					ALU_ORA: begin
						nxt.a = cur.a | operand;
						nxt.p = with_nz(cur.p, cur.a | operand);
					end
					ALU_AND: begin
						nxt.a = and_am;
						nxt.p = with_nz(cur.p, and_am);
					end
					ALU_EOR: begin
						nxt.a = cur.a ^ operand;
						nxt.p = with_nz(cur.p, cur.a ^ operand);
					end
					ALU_ADC: begin
						nxt.a        = adc_res;
						nxt.p        = with_nz(cur.p, adc_res);
						nxt.p[F_C]   = |adc_t[9:8];
						nxt.p[F_V]   = adc_v;
					end
					ALU_STA: begin
						res.write_data   = cur.a;
						res.write_enable = 1'b1;
					end
					ALU_LDA: begin
						nxt.a = operand;
						nxt.p = with_nz(cur.p, operand);
					end
					ALU_CMP: begin
						nxt.p      = with_nz(cur.p, cmp_diff);
						nxt.p[F_C] = (cur.a >= operand);
					end
					ALU_SBC: begin
						nxt.a      = sbc_res;
						nxt.p      = with_nz(cur.p, sbc_res);
						nxt.p[F_C] = ~sbc_full[9];
						nxt.p[F_V] = sbc_v;
					end
					default: nxt = cur;
				endcase
			end
			K_CPX, K_CPY: begin
				nxt.p      = with_nz(cur.p, cmp_diff);
				nxt.p[F_C] = (cmp_reg >= operand);
			end
			K_SHM: begin
				res.write_data   = sh_mem[7:0];
				res.write_enable = 1'b1;
				nxt.p            = with_nz(cur.p, sh_mem[7:0]);
				nxt.p[F_C]       = sh_mem[8];
			end
			K_SHA: begin
				nxt.a      = sh_acc[7:0];
				nxt.p      = with_nz(cur.p, sh_acc[7:0]);
				nxt.p[F_C] = sh_acc[8];
			end
			K_INCM: begin
				res.write_data   = operand + 8'd1;
				res.write_enable = 1'b1;
				nxt.p            = with_nz(cur.p, operand + 8'd1);
			end
			K_DECM: begin
				res.write_data   = operand - 8'd1;
				res.write_enable = 1'b1;
				nxt.p            = with_nz(cur.p, operand - 8'd1);
			end
			K_INA: begin
				nxt.a = cur.a + 8'd1;
				nxt.p = with_nz(cur.p, cur.a + 8'd1);
			end
			K_DEA: begin
				nxt.a = cur.a - 8'd1;
				nxt.p = with_nz(cur.p, cur.a - 8'd1);
			end
			K_INX: begin
				nxt.x = cur.x + 8'd1;
				nxt.p = with_nz(cur.p, cur.x + 8'd1);
			end
			K_DEX: begin
				nxt.x = cur.x - 8'd1;
				nxt.p = with_nz(cur.p, cur.x - 8'd1);
			end
			K_INY: begin
				nxt.y = cur.y + 8'd1;
				nxt.p = with_nz(cur.p, cur.y + 8'd1);
			end
			K_DEY: begin
				nxt.y = cur.y - 8'd1;
				nxt.p = with_nz(cur.p, cur.y - 8'd1);
			end
			K_LDX: begin
				nxt.x = operand;
				nxt.p = with_nz(cur.p, operand);
			end
			K_LDY: begin
				nxt.y = operand;
				nxt.p = with_nz(cur.p, operand);
			end
			K_STX: begin
				res.write_data   = cur.x;
				res.write_enable = 1'b1;
			end
			K_STY: begin
				res.write_data   = cur.y;
				res.write_enable = 1'b1;
			end
			K_STZ: res.write_enable = 1'b1;
			K_BIT: begin
				nxt.p[F_N] = operand[7];
				nxt.p[F_V] = operand[6];
				nxt.p[F_Z] = (and_am == 8'd0);
			end
			K_BITI: nxt.p[F_Z] = (and_am == 8'd0);
			K_TSB: begin
				nxt.p[F_Z]       = (and_am == 8'd0);
				res.write_data   = operand | cur.a;
				res.write_enable = 1'b1;
			end
			K_TRB: begin
				nxt.p[F_Z]       = (and_am == 8'd0);
				res.write_data   = operand & ~cur.a;
				res.write_enable = 1'b1;
			end
			K_TAX: begin
				nxt.x = cur.a;
				nxt.p = with_nz(cur.p, cur.a);
			end
			K_TAY: begin
				nxt.y = cur.a;
				nxt.p = with_nz(cur.p, cur.a);
			end
			K_TXA: begin
				nxt.a = cur.x;
				nxt.p = with_nz(cur.p, cur.x);
			end
			K_TYA: begin
				nxt.a = cur.y;
				nxt.p = with_nz(cur.p, cur.y);
			end
			K_TSX: begin
				nxt.x = cur.sp;
				nxt.p = with_nz(cur.p, cur.sp);
			end
			K_TXS: nxt.sp = cur.x;
			K_PHA, K_PHP, K_PHX, K_PHY: begin
				priority case (dec.kind)
					K_PHA: res.write_data = cur.a;
					K_PHP: res.write_data = cur.p;
					K_PHX: res.write_data = cur.x;
					default: res.write_data = cur.y;
				endcase
				res.write_enable = 1'b1;
				nxt.sp           = cur.sp - 8'd1;
			end
			K_PLA: begin
				nxt.sp = cur.sp + 8'd1;
				nxt.a  = operand;
				nxt.p  = with_nz(cur.p, operand);
			end
			K_PLP: begin
				nxt.sp = cur.sp + 8'd1;
				nxt.p  = operand;
			end
			K_PLX: begin
				nxt.sp = cur.sp + 8'd1;
				nxt.x  = operand;
				nxt.p  = with_nz(cur.p, operand);
			end
			K_PLY: begin
				nxt.sp = cur.sp + 8'd1;
				nxt.y  = operand;
				nxt.p  = with_nz(cur.p, operand);
			end
			K_BR:  res.branch_taken = (flag_sel == dec.row[0]);
			K_BRA: res.branch_taken = 1'b1;
			K_CLC: nxt.p[F_C] = 1'b0;
			K_SEC: nxt.p[F_C] = 1'b1;
			K_CLI: nxt.p[F_I] = 1'b0;
			K_SEI: nxt.p[F_I] = 1'b1;
			K_CLV: nxt.p[F_V] = 1'b0;
			K_CLD: nxt.p[F_D] = 1'b0;
			K_SED: nxt.p[F_D] = 1'b1;
			K_NOP: nxt = cur;
			K_UNK: res.unknown_opcode = 1'b1;
			default: res.unknown_opcode = 1'b1;
		endcase
		res.status_out = nxt.p;
	end

endmodule

// File: hw/rtl/cpu8_alu_execute_stage_unit.sv
// ---------------------------------------------------------------------------
// cpu8_alu_execute_stage_unit
// execute stage of an 8-bit 65c02-style cpu with decimal mode
// ---------------------------------------------------------------------------
// One instruction request (opcode and fetched operand) is taken per clock
// while the output is not stalled. The opcode is decoded into an input
// register; from there the execute logic updates A, X, Y, SP and the status
// byte and loads the result into an output register, and requests may follow
// back to back at one per cycle unless m_tready holds the output. That rate is
// set by the loop through the execute logic and the register file. The output
// register lets a new request enter while a result waits to be taken.
module cpu8_alu_execute_stage_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// opcode[7:0], operand[15:8]
	input  logic [cpu8_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// write_data[7:0], write_enable[8], branch_taken[9], status_out[17:10],
	// unknown_opcode[18], zero[23:19]
	output logic [cpu8_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import cpu8_pkg::*;

	`include "assert_macros.svh"

	dec_t       dec_in;
	dec_t       dec_s1;
	logic [7:0] operand_s1;
	logic       valid_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res_nxt;
	regs_t      regs_q;
	regs_t      regs_nxt;
	logic       s1_move;

	cpu8_dec u_dec (
		.opcode (s_tdata[7:0]),
		.dec    (dec_in)
	);

	cpu8_alu u_alu (
		.dec     (dec_s1),
		.operand (operand_s1),
		.cur     (regs_q),
		.nxt     (regs_nxt),
		.res     (res_nxt)
	);

	assign s1_move  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || s1_move;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.unknown_opcode, res_s2.status_out,
		res_s2.branch_taken, res_s2.write_enable, res_s2.write_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			regs_q   <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: 8'd0};
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (s1_move)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
			if (s1_move)
				regs_q <= regs_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dec_s1     <= dec_in;
			operand_s1 <= s_tdata[15:8];
		end
		if (s1_move)
			res_s2 <= res_nxt;
	end

	// unhandled opcodes leave the register file untouched
	`ASSERT_NEXT(a_unk_keeps_state, s1_move && dec_s1.kind == K_UNK, $stable(regs_q), "unknown opcode changed state")
	// status in the result matches the status register as updated by its request
	`ASSERT_NEXT(a_status_match, s1_move, res_s2.status_out == regs_q.p, "status_out differs from status register")
	// pushes step the stack pointer down by one
	`ASSERT_NEXT(a_push_sp, s1_move && (dec_s1.kind == K_PHA || dec_s1.kind == K_PHP || dec_s1.kind == K_PHX || dec_s1.kind == K_PHY), regs_q.sp == 8'($past(regs_q.sp) - 8'd1), "push did not decrement sp")
	// no write data without a write enable
	`ASSERT_SAME(a_wd_zero, valid_s2 && !res_s2.write_enable, res_s2.write_data == 8'd0, "write_data set without write_enable")

endmodule
